// ===== hw/rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants of the odometry block
// Register indexes, reset values, CORDIC tables and controller commands.
// ----------------------------------------------------------------------------
package ddo_pkg;

  typedef logic [7:0] cfg_idx_t;

  localparam cfg_idx_t REG_LENGTH_PER_STEP = 8'd0;
  localparam cfg_idx_t REG_ANGLE_PER_STEP  = 8'd1;

  localparam logic [15:0] LPS_RESET = 16'd852;
  localparam logic [15:0] APS_RESET = 16'd6489;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ZERO = 1'b1;

  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;

  // arctangent of 2^-i in 2^-32 turns
  localparam logic [31:0] ATAN_TURNS32 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    MUL_HEAD = 3'd0,
    MUL_DIST = 3'd1,
    MUL_CLO  = 3'd2,
    MUL_CHI  = 3'd3,
    MUL_SLO  = 3'd4,
    MUL_SHI  = 3'd5
  } mul_sel_e;

  typedef enum logic [2:0] {
    TAKE_NONE = 3'd0,
    TAKE_HEAD = 3'd1,
    TAKE_DIST = 3'd2,
    TAKE_ACC  = 3'd3,
    TAKE_X    = 3'd4,
    TAKE_Y    = 3'd5
  } take_e;

  typedef struct packed {
    logic     capture;
    logic     delta;
    logic     clear;
    logic     cord_init;
    logic     cord_step;
    logic     cord_fin;
    mul_sel_e mul_sel;
    take_e    take;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic op_zero;
    logic cord_last;
  } sts_t;

endpackage

// ===== hw/rtl/ddo_if.sv =====
// ----------------------------------------------------------------------------
// ddo_if: channel interfaces of the odometry block
// Tick input, pose output and configuration write channels.
// ----------------------------------------------------------------------------
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] right_count;
  logic signed [31:0] left_count;

  modport source (output valid, op, right_count, left_count, input ready);
  modport sink   (input valid, op, right_count, left_count, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic signed [15:0] heading;

  modport source (output valid, x_pos, y_pos, heading, input ready);
  modport sink   (input valid, x_pos, y_pos, heading, output ready);
endinterface

interface ddo_cfg_if;
  logic             valid;
  logic             ready;
  ddo_pkg::cfg_idx_t index;
  logic [15:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ddo_datapath.sv =====
// ----------------------------------------------------------------------------
// ddo_datapath: pose registers, shared multiplier and iterative CORDIC
// Executes one controller command per cycle.
// ----------------------------------------------------------------------------
module ddo_datapath #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddo_pkg::cmd_t      cmd_i,
  output ddo_pkg::sts_t      sts_o,
  input  logic               op_i,
  input  logic signed [31:0] right_count_i,
  input  logic signed [31:0] left_count_i,
  input  logic [15:0]        length_per_step_i,
  input  logic [15:0]        angle_per_step_i,
  output logic signed [31:0] x_pos_o,
  output logic signed [31:0] y_pos_o,
  output logic signed [15:0] heading_o
);

  localparam int ZW    = ANGLE_BITS + 2;
  localparam int IW    = ZW + 16;
  localparam int TSH   = 32 - ANGLE_BITS;
  localparam int SHL   = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int SHR   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam int IDX_W = $clog2(CORDIC_STEPS);
  localparam int XW    = 33;
  localparam logic signed [XW-1:0] UNIT_POS = XW'(65536);
  localparam logic signed [XW-1:0] UNIT_NEG = -XW'(65536);

  // tick operands
  logic               op_q;
  logic [31:0]        rc_q, lc_q;
  logic [31:0]        prev_r_q, prev_r_d, prev_l_q, prev_l_d;
  logic [23:0]        diff_q, diff_d;
  logic [31:0]        half_q, half_d;
  logic [32:0]        sum, hsum;
  logic [31:0]        dr, dl;

  // multiplier
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod_q;
  logic [47:0]        dist_q, acc_q;
  logic [23:0]        head_inc;
  logic [47:0]        incr;

  // pose
  logic [31:0]        pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [15:0]        head_q, head_d;

  // CORDIC
  logic [ANGLE_BITS-1:0]    step_tab [CORDIC_STEPS];
  logic signed [XW-1:0]     cx_q, cx_d, cy_q, cy_d, xs, ys;
  logic signed [ZW-1:0]     cz_q, cz_d;
  logic [IDX_W-1:0]         iter_q, iter_d;
  logic                     flip_q, flip_d;
  logic [15:0]              a16;
  logic signed [IW-1:0]     zext;
  logic signed [XW-1:0]     fx, fy, rx, ry;
  logic signed [17:0]       cos_q, sin_q, cos_d, sin_d;

  always_comb begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      step_tab[k] = ANGLE_BITS'((33'(ddo_pkg::ATAN_TURNS32[k]) + (33'd1 << (TSH - 1))) >> TSH);
    end
  end

  // deltas
  assign dr     = rc_q - prev_r_q;
  assign dl     = lc_q - prev_l_q;
  assign sum    = {dr[31], dr} + {dl[31], dl};
  assign hsum   = sum + {32'b0, sum[32]};
  assign half_d = hsum[32:1];
  assign diff_d = dr[23:0] - dl[23:0];

  always_comb begin
    case (cmd_i.mul_sel)
      ddo_pkg::MUL_HEAD: begin
        mul_a = {9'b0, diff_q};
        mul_b = {2'b0, angle_per_step_i};
      end
      ddo_pkg::MUL_DIST: begin
        mul_a = {half_q[31], half_q};
        mul_b = {2'b0, length_per_step_i};
      end
      ddo_pkg::MUL_CLO: begin
        mul_a = {9'b0, dist_q[23:0]};
        mul_b = cos_q;
      end
      ddo_pkg::MUL_CHI: begin
        mul_a = {9'b0, dist_q[47:24]};
        mul_b = cos_q;
      end
      ddo_pkg::MUL_SLO: begin
        mul_a = {9'b0, dist_q[23:0]};
        mul_b = sin_q;
      end
      ddo_pkg::MUL_SHI: begin
        mul_a = {9'b0, dist_q[47:24]};
        mul_b = sin_q;
      end
      default: begin
        mul_a = {9'b0, diff_q};
        mul_b = {2'b0, angle_per_step_i};
      end
    endcase
  end

  assign head_inc = prod_q[23:0] + 24'd128;
  assign incr     = acc_q + {prod_q[23:0], 24'b0} + 48'd32768;

  always_comb begin
    prev_r_d = prev_r_q;
    prev_l_d = prev_l_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    head_d   = head_q;
    if (cmd_i.delta) begin
      prev_r_d = rc_q;
      prev_l_d = lc_q;
    end
    case (cmd_i.take)
      ddo_pkg::TAKE_HEAD: head_d  = head_q + head_inc[23:8];
      ddo_pkg::TAKE_X:    pos_x_d = pos_x_q + incr[47:16];
      ddo_pkg::TAKE_Y:    pos_y_d = pos_y_q + incr[47:16];
      default: ;
    endcase
    if (cmd_i.clear) begin
      pos_x_d = '0;
      pos_y_d = '0;
      head_d  = '0;
    end
  end

  // CORDIC rotation step and angle folding
  assign xs = cx_q >>> iter_q;
  assign ys = cy_q >>> iter_q;

  always_comb begin
    a16    = {head_q[15] ^ (head_q[15] ^ head_q[14]), head_q[14:0]};
    zext   = IW'($signed(a16));
    zext   = (zext <<< SHL) >>> SHR;
    cx_d   = cx_q;
    cy_d   = cy_q;
    cz_d   = cz_q;
    iter_d = iter_q;
    flip_d = flip_q;
    if (cmd_i.cord_init) begin
      cx_d   = {1'b0, ddo_pkg::CORDIC_GAIN_Q30};
      cy_d   = '0;
      cz_d   = zext[ZW-1:0];
      iter_d = '0;
      flip_d = head_q[15] ^ head_q[14];
    end else if (cmd_i.cord_step) begin
      iter_d = iter_q + IDX_W'(1);
      if (!cz_q[ZW-1]) begin
        cx_d = cx_q - ys;
        cy_d = cy_q + xs;
        cz_d = cz_q - $signed({2'b0, step_tab[iter_q]});
      end else begin
        cx_d = cx_q + ys;
        cy_d = cy_q - xs;
        cz_d = cz_q + $signed({2'b0, step_tab[iter_q]});
      end
    end
  end

  assign fx = flip_q ? -cx_q : cx_q;
  assign fy = flip_q ? -cy_q : cy_q;
  assign rx = (fx + XW'(8192)) >>> 14;
  assign ry = (fy + XW'(8192)) >>> 14;

  always_comb begin
    if (rx > UNIT_POS) begin
      cos_d = UNIT_POS[17:0];
    end else if (rx < UNIT_NEG) begin
      cos_d = UNIT_NEG[17:0];
    end else begin
      cos_d = rx[17:0];
    end
    if (ry > UNIT_POS) begin
      sin_d = UNIT_POS[17:0];
    end else if (ry < UNIT_NEG) begin
      sin_d = UNIT_NEG[17:0];
    end else begin
      sin_d = ry[17:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_r_q <= '0;
      prev_l_q <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      head_q   <= '0;
      iter_q   <= '0;
    end else begin
      prev_r_q <= prev_r_d;
      prev_l_q <= prev_l_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      head_q   <= head_d;
      iter_q   <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    flip_q <= flip_d;
    if (cmd_i.capture) begin
      op_q <= op_i;
      rc_q <= right_count_i;
      lc_q <= left_count_i;
    end
    if (cmd_i.delta) begin
      diff_q <= diff_d;
      half_q <= half_d;
    end
    if (cmd_i.take == ddo_pkg::TAKE_DIST) begin
      dist_q <= prod_q[47:0];
    end
    if (cmd_i.take == ddo_pkg::TAKE_ACC) begin
      acc_q <= prod_q[47:0];
    end
    if (cmd_i.cord_fin) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
    if (cmd_i.out_load) begin
      x_pos_o   <= pos_x_q;
      y_pos_o   <= pos_y_q;
      heading_o <= head_q;
    end
  end

  assign sts_o.op_zero   = (op_q == ddo_pkg::OP_ZERO);
  assign sts_o.cord_last = (iter_q == IDX_W'(CORDIC_STEPS - 1));

  a_iter_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cord_init |=> iter_q == '0)
    else $error("cordic counter not restarted");

  a_clear_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (pos_x_q == '0 && pos_y_q == '0 && head_q == '0))
    else $error("pose not cleared");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cord_fin |=> (cos_q <= UNIT_POS && cos_q >= UNIT_NEG &&
                        sin_q <= UNIT_POS && sin_q >= UNIT_NEG))
    else $error("cosine or sine out of unit range");

endmodule

// ===== hw/rtl/ddo_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddo_ctrl: sequencer of the odometry block
// Steps the datapath through deltas, heading, distance, CORDIC and update, or clears the pose for a zero operation.
// ----------------------------------------------------------------------------
module ddo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ddo_pkg::sts_t sts_i,
  output ddo_pkg::cmd_t cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_DELTA = 13'b0000000000010,
    ST_MHEAD = 13'b0000000000100,
    ST_HEAD  = 13'b0000000001000,
    ST_DIST  = 13'b0000000010000,
    ST_CORD  = 13'b0000000100000,
    ST_CFIN  = 13'b0000001000000,
    ST_XLO   = 13'b0000010000000,
    ST_XHI   = 13'b0000100000000,
    ST_XADD  = 13'b0001000000000,
    ST_YHI   = 13'b0010000000000,
    ST_YADD  = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.mul_sel = ddo_pkg::MUL_HEAD;
    cmd_o.take    = ddo_pkg::TAKE_NONE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = accept;
        if (accept) state_d = ST_DELTA;
      end
      ST_DELTA: begin
        if (sts_i.op_zero) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_DONE;
        end else begin
          cmd_o.delta = 1'b1;
          state_d     = ST_MHEAD;
        end
      end
      ST_MHEAD: begin
        cmd_o.mul_sel = ddo_pkg::MUL_HEAD;
        state_d       = ST_HEAD;
      end
      ST_HEAD: begin
        cmd_o.take    = ddo_pkg::TAKE_HEAD;
        cmd_o.mul_sel = ddo_pkg::MUL_DIST;
        state_d       = ST_DIST;
      end
      ST_DIST: begin
        cmd_o.take      = ddo_pkg::TAKE_DIST;
        cmd_o.cord_init = 1'b1;
        state_d         = ST_CORD;
      end
      ST_CORD: begin
        cmd_o.cord_step = 1'b1;
        if (sts_i.cord_last) state_d = ST_CFIN;
      end
      ST_CFIN: begin
        cmd_o.cord_fin = 1'b1;
        state_d        = ST_XLO;
      end
      ST_XLO: begin
        cmd_o.mul_sel = ddo_pkg::MUL_CLO;
        state_d       = ST_XHI;
      end
      ST_XHI: begin
        cmd_o.take    = ddo_pkg::TAKE_ACC;
        cmd_o.mul_sel = ddo_pkg::MUL_CHI;
        state_d       = ST_XADD;
      end
      ST_XADD: begin
        cmd_o.take    = ddo_pkg::TAKE_X;
        cmd_o.mul_sel = ddo_pkg::MUL_SLO;
        state_d       = ST_YHI;
      end
      ST_YHI: begin
        cmd_o.take    = ddo_pkg::TAKE_ACC;
        cmd_o.mul_sel = ddo_pkg::MUL_SHI;
        state_d       = ST_YADD;
      end
      ST_YADD: begin
        cmd_o.take = ddo_pkg::TAKE_Y;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_DELTA)
    else $error("transfer did not start a sequence");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_cord_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORD && sts_i.cord_last) |=> state_q == ST_CFIN)
    else $error("cordic loop overran");

endmodule

// ===== hw/rtl/differential_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry: dead-reckoning pose tracker, two-wheel drive
// Tracks x, y and heading from absolute wheel step counts.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          transfer
//  in_i     in   op, right_count, left_count      valid & ready
//  out_o    out  x_pos, y_pos, heading            valid & ready
//  cfg_i    in   index, data (16 bit)             valid & ready, ready always 1
//
//  A tick runs from transfer to result through the serial CORDIC loop plus
//  six passes through the one shared multiplier.
//  A new item is taken once the previous one is in the output register,
//  even if that result is still waiting on out_o.
//  Reset clears the pose and stored counts and loads the default registers.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddo_cfg_if.sink    cfg_i,
  ddo_in_if.sink     in_i,
  ddo_out_if.source  out_o
);

  logic [15:0]   lps_q, aps_q;
  ddo_pkg::cmd_t cmd;
  ddo_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lps_q <= ddo_pkg::LPS_RESET;
      aps_q <= ddo_pkg::APS_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == ddo_pkg::REG_LENGTH_PER_STEP) lps_q <= cfg_i.data;
      if (cfg_i.index == ddo_pkg::REG_ANGLE_PER_STEP)  aps_q <= cfg_i.data;
    end
  end

  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ddo_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .op_i              (in_i.op),
    .right_count_i     (in_i.right_count),
    .left_count_i      (in_i.left_count),
    .length_per_step_i (lps_q),
    .angle_per_step_i  (aps_q),
    .x_pos_o           (out_o.x_pos),
    .y_pos_o           (out_o.y_pos),
    .heading_o         (out_o.heading)
  );

endmodule
